// File: design/scg_pkg.sv
// shared types and constants for the sprite command geometry block
// holds the decoded sprite descriptor and command codes; no dependencies
package scg_pkg;

  localparam int WORD_W            = 16;
  localparam int ENTRY_WORDS       = 14;
  localparam int COMMAND_WORDS_DEF = 14;
  localparam int QUEUE_DEPTH       = 2;
  localparam int OUT_DATA_W        = 128;
  localparam int COUNT_W           = 14;
  localparam int COORD_W           = 17;
  localparam int POS_W             = 18;

  localparam logic [3:0] CMD_NORMAL    = 4'h0;
  localparam logic [3:0] CMD_SCALED    = 4'h1;
  localparam logic [3:0] CMD_DISTORTED = 4'h2;
  localparam logic [3:0] CMD_LOCAL     = 4'hA;

  localparam logic [2:0] PAL_MODE_LUT = 3'd1;

  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BR = 2'd2;
  localparam logic [1:0] CORNER_BL = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0]                cmd_index;
    logic [COUNT_W-1:0]                obj_num;
    logic [3:0][COORD_W-1:0]           cx;
    logic [3:0][COORD_W-1:0]           cy;
    logic [WORD_W-1:0]                 ox;
    logic [WORD_W-1:0]                 oy;
    logic [8:0]                        u0;
    logic [8:0]                        u1;
    logic [7:0]                        v0;
    logic [7:0]                        v1;
    logic [2:0]                        mode;
    logic                              transp;
    logic                              gouraud;
    logic [18:0]                       tex_addr;
    logic [18:0]                       pal;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_word_t;

endpackage

// File: design/scg_front.sv
// front end: gathers command entry words, decodes each complete entry
// keeps origin and counts, pushes sprite descriptors; uses scg_pkg
module scg_front #(
  parameter int COMMAND_WORDS = scg_pkg::COMMAND_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [scg_pkg::WORD_W-1:0] word,
  input  logic                      list_start,
  input  logic                      full,
  output scg_pkg::desc_word_t       push
);
  import scg_pkg::*;

  localparam int PW = $clog2(COMMAND_WORDS);
  localparam int EW = $clog2(ENTRY_WORDS);

  logic [PW-1:0]      pos;
  logic [WORD_W-1:0]  entry [ENTRY_WORDS];
  logic [WORD_W-1:0]  origin_x, origin_y;
  logic [COUNT_W-1:0] cmd_count, spr_count;

  logic [PW-1:0]      pos_eff;
  logic [WORD_W-1:0]  ox_eff, oy_eff;
  logic [COUNT_W-1:0] cmd_eff, spr_eff;
  logic [WORD_W-1:0]  view [ENTRY_WORDS];
  logic               last, accept, is_sprite, is_local;
  logic [3:0]         comm;
  logic [8:0]         width;
  logic [7:0]         height;
  logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc, xd, yd, xw, yh;
  desc_t              d;

  assign pos_eff = list_start ? '0 : pos;
  assign ox_eff  = list_start ? '0 : origin_x;
  assign oy_eff  = list_start ? '0 : origin_y;
  assign cmd_eff = list_start ? '0 : cmd_count;
  assign spr_eff = list_start ? '0 : spr_count;
  assign last    = pos_eff == PW'(COMMAND_WORDS - 1);
  assign s_tready = !full || !last;
  assign accept  = s_tvalid && s_tready;

  // the word arriving now stands in for its slot in the decode
  always_comb begin
    for (int i = 0; i < ENTRY_WORDS; i++) begin
      view[i] = (pos_eff == PW'(i)) ? word : entry[i];
    end
  end

  assign comm   = view[0][3:0];
  assign width  = {view[5][13:8], 3'b000};
  assign height = view[5][7:0];
  assign xa = $signed({view[6][15], view[6]});
  assign ya = $signed({view[7][15], view[7]});
  assign xb = $signed({view[8][15], view[8]});
  assign yb = $signed({view[9][15], view[9]});
  assign xc = $signed({view[10][15], view[10]});
  assign yc = $signed({view[11][15], view[11]});
  assign xd = $signed({view[12][15], view[12]});
  assign yd = $signed({view[13][15], view[13]});
  assign xw = xa + $signed({8'b0, width});
  assign yh = ya + $signed({9'b0, height});
  assign is_local = comm == CMD_LOCAL;

  always_comb begin
    d = '0;
    d.cmd_index = cmd_eff;
    d.obj_num   = spr_eff;
    d.ox        = ox_eff;
    d.oy        = oy_eff;
    is_sprite   = !view[0][14] && (view[5][13:8] != '0) && (height != '0);
    case (comm)
      CMD_NORMAL: begin
        d.cx = {xa, xw, xw, xa};
        d.cy = {yh, yh, ya, ya};
      end
      CMD_SCALED: begin
        d.cx = {xa, xc, xc, xa};
        d.cy = {yc, yc, ya, ya};
      end
      CMD_DISTORTED: begin
        d.cx = {xd, xc, xb, xa};
        d.cy = {yd, yc, yb, ya};
      end
      default: begin
        is_sprite = 1'b0;
      end
    endcase
    // flip bits swap the corner texture coordinates
    d.u0       = view[0][4] ? width : 9'd0;
    d.u1       = view[0][4] ? 9'd0 : width;
    d.v0       = view[0][5] ? height : 8'd0;
    d.v1       = view[0][5] ? 8'd0 : height;
    d.mode     = view[2][5:3];
    d.transp   = !view[2][6];
    d.gouraud  = view[2][2];
    d.tex_addr = {view[4], 3'b000};
    d.pal      = (view[2][5:3] == PAL_MODE_LUT) ? {view[3], 3'b000} : {3'b000, view[3]};
  end

  assign push.valid = accept && last && is_sprite;
  assign push.desc  = d;

  always_ff @(posedge clk) begin
    if (accept && (pos_eff < PW'(ENTRY_WORDS))) begin
      entry[pos_eff[EW-1:0]] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      origin_x  <= '0;
      origin_y  <= '0;
      cmd_count <= '0;
      spr_count <= '0;
    end else if (accept) begin
      pos       <= last ? '0 : pos_eff + 1'b1;
      cmd_count <= last ? cmd_eff + 1'b1 : cmd_eff;
      spr_count <= push.valid ? spr_eff + 1'b1 : spr_eff;
      if (last && is_local) begin
        origin_x <= view[6];
        origin_y <= view[7];
      end else begin
        origin_x <= ox_eff;
        origin_y <= oy_eff;
      end
    end
  end

endmodule

// File: design/scg_queue.sv
// short descriptor queue between the front and back ends
// register based fifo of scg_pkg::desc_t entries
module scg_queue (
  input  logic                clk,
  input  logic                rst,
  input  scg_pkg::desc_word_t push,
  input  logic                pop,
  output logic                full,
  output scg_pkg::desc_word_t head
);
  import scg_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  desc_t         mem [QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = count == CW'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.desc  = mem[rptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/scg_back.sv
// back end: steps through the four corners of the queue head
// adds the origin and fills the output register; uses scg_pkg
module scg_back (
  input  logic                            clk,
  input  logic                            rst,
  input  scg_pkg::desc_word_t             head,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [scg_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import scg_pkg::*;

  logic [1:0]         k;
  logic               load;
  logic [COUNT_W-1:0] cmd_index, obj_num;
  logic [1:0]         corner;
  logic [POS_W-1:0]   pos_x, pos_y;
  logic [8:0]         tex_u;
  logic [7:0]         tex_v;
  logic [2:0]         pix_mode;
  logic               transp, gouraud;
  logic [18:0]        tex_addr, pal;
  logic [COORD_W-1:0] cx_k, cy_k;

  assign load = head.valid && (!m_tvalid || m_tready);
  assign pop  = load && (k == CORNER_BL);
  assign cx_k = head.desc.cx[k];
  assign cy_k = head.desc.cy[k];

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= CORNER_TL;
      m_tvalid <= 1'b0;
    end else if (load) begin
      k        <= k + 1'b1;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_index  <= head.desc.cmd_index;
      obj_num    <= head.desc.obj_num;
      corner     <= k;
      pos_x      <= {cx_k[COORD_W-1], cx_k}
                  + {{(POS_W-WORD_W){head.desc.ox[WORD_W-1]}}, head.desc.ox};
      pos_y      <= {cy_k[COORD_W-1], cy_k}
                  + {{(POS_W-WORD_W){head.desc.oy[WORD_W-1]}}, head.desc.oy};
      tex_u      <= (k == CORNER_TL || k == CORNER_BL) ? head.desc.u0 : head.desc.u1;
      tex_v      <= (k == CORNER_TL || k == CORNER_TR) ? head.desc.v0 : head.desc.v1;
      pix_mode   <= head.desc.mode;
      transp     <= head.desc.transp;
      gouraud    <= head.desc.gouraud;
      tex_addr   <= head.desc.tex_addr;
      pal        <= head.desc.pal;
    end
  end

  assign m_tdata = {2'b00, pal, tex_addr, gouraud, transp, pix_mode, tex_v, tex_u,
                    pos_y, pos_x, corner, obj_num, cmd_index};

endmodule

// File: design/sprite_command_geometry.sv
// sprite command geometry top level: front end, descriptor queue, back end
// depends on scg_pkg, scg_front, scg_queue and scg_back
//
// Takes one 16-bit command word per cycle; an entry is COMMAND_WORDS words
// and is decoded as its last word is taken. Each drawable sprite command puts
// one descriptor into a two-entry queue, and the back end turns it into four
// corner words, one per cycle from a corner counter unless the output stalls,
// through an output register. The input stalls only on the last word of an
// entry while the queue is full, so a steady stream of entries runs at one
// word per cycle. Each descriptor is held in the queue, each corner word in
// the output register. tuser on the input is the list start flag.
module sprite_command_geometry #(
  parameter int COMMAND_WORDS = scg_pkg::COMMAND_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // word [15:0]
  input  logic [15:0]                     s_tdata,
  // list_start [0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // cmd_idx [13:0], spr_num [27:14], corner [29:28], pos_x [47:30],
  // pos_y [65:48], tex_u [74:66], tex_v [82:75], pix_mode [85:83],
  // pixel_transparency [86], gouraud [87], texture_address [106:88],
  // palette_value [125:107], zero [127:126]
  output logic [scg_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import scg_pkg::*;

  desc_word_t push, head;
  logic       full, pop;

  scg_front #(.COMMAND_WORDS(COMMAND_WORDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .word       (s_tdata),
    .list_start (s_tuser),
    .full       (full),
    .push       (push)
  );

  scg_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (full),
    .head (head)
  );

  scg_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // corners of one sprite follow back to back
  a_corner_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tdata[29:28] != CORNER_BL)
      |=> (m_tvalid && m_tdata[29:28] == $past(m_tdata[29:28]) + 2'd1))
    else $error("corner sequence broken");

  a_same_sprite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tdata[29:28] != CORNER_BL)
      |=> (m_tdata[27:0] == $past(m_tdata[27:0])))
    else $error("sprite numbers change within a sprite");

  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tdata[29:28] == CORNER_BL && m_tvalid)
      |=> (!m_tvalid || m_tdata[29:28] == CORNER_TL))
    else $error("sprite does not start at top-left");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

// File: bench/tb.sv
// testbench for sprite_command_geometry: streams command entries and checks corner words
// depends on scg_pkg and the sprite_command_geometry block only
module tb;
  import scg_pkg::*;

  localparam int CYCLE_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_WORDS = 56;

  // output word as laid out on m_tdata, highest field first
  typedef struct packed {
    logic [1:0]         pad;
    logic [18:0]        palette_value;
    logic [18:0]        texture_address;
    logic               gouraud;
    logic               pixel_transparency;
    logic [2:0]         pix_mode;
    logic [7:0]         tex_v;
    logic [8:0]         tex_u;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_x;
    logic [1:0]         corner;
    logic [13:0]        spr_num;
    logic [13:0]        cmd_idx;
  } corner_word_t;

  typedef logic [15:0] entry_t [ENTRY_WORDS];

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // predictor state
  logic [15:0]  entry_buf [ENTRY_WORDS];
  int unsigned  fill_pos = 0;
  logic [15:0]  org_x = '0;
  logic [15:0]  org_y = '0;
  logic [13:0]  cmd_count = '0;
  logic [13:0]  sprite_count = '0;
  corner_word_t expected_corners [$];

  int  error_count = 0;
  int  words_sent = 0;
  int  corners_checked = 0;
  int  list_restarts = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  int  hold_asked = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  sprite_command_geometry uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // decode a complete entry into its four corners, update the origin, or skip it
  function automatic void decode_entry();
    logic [15:0] ctrl, pmod, colr, srca, size;
    logic [3:0]  code;
    logic [8:0]  width;
    logic [7:0]  height;
    logic [8:0]  u_lo, u_hi;
    logic [7:0]  v_lo, v_hi;
    logic [8:0]  tu [4];
    logic [7:0]  tv [4];
    int          px [4], py [4];
    int          xa, ya, xb, yb, xc, yc, xd, yd, ox, oy;
    corner_word_t cw;
    ctrl = entry_buf[0];
    pmod = entry_buf[2];
    colr = entry_buf[3];
    srca = entry_buf[4];
    size = entry_buf[5];
    code = ctrl[3:0];
    if (code == CMD_LOCAL) begin
      org_x = entry_buf[6];
      org_y = entry_buf[7];
      return;
    end
    // jump modes 4..7 all skip
    if (ctrl[14] || code > CMD_DISTORTED) return;
    width = {size[13:8], 3'b000};
    height = size[7:0];
    if (width == 0 || height == 0) return;
    xa = int'($signed(entry_buf[6]));
    ya = int'($signed(entry_buf[7]));
    xb = int'($signed(entry_buf[8]));
    yb = int'($signed(entry_buf[9]));
    xc = int'($signed(entry_buf[10]));
    yc = int'($signed(entry_buf[11]));
    xd = int'($signed(entry_buf[12]));
    yd = int'($signed(entry_buf[13]));
    ox = int'($signed(org_x));
    oy = int'($signed(org_y));
    px[CORNER_TL] = xa;
    py[CORNER_TL] = ya;
    if (code == CMD_NORMAL) begin
      px[CORNER_TR] = xa + int'(width);  py[CORNER_TR] = ya;
      px[CORNER_BR] = xa + int'(width);  py[CORNER_BR] = ya + int'(height);
      px[CORNER_BL] = xa;                py[CORNER_BL] = ya + int'(height);
    end else if (code == CMD_SCALED) begin
      px[CORNER_TR] = xc;  py[CORNER_TR] = ya;
      px[CORNER_BR] = xc;  py[CORNER_BR] = yc;
      px[CORNER_BL] = xa;  py[CORNER_BL] = yc;
    end else begin
      px[CORNER_TR] = xb;  py[CORNER_TR] = yb;
      px[CORNER_BR] = xc;  py[CORNER_BR] = yc;
      px[CORNER_BL] = xd;  py[CORNER_BL] = yd;
    end
    // flips swap the texture extents
    u_lo = ctrl[4] ? width : 9'd0;
    u_hi = ctrl[4] ? 9'd0 : width;
    v_lo = ctrl[5] ? height : 8'd0;
    v_hi = ctrl[5] ? 8'd0 : height;
    tu[CORNER_TL] = u_lo;  tv[CORNER_TL] = v_lo;
    tu[CORNER_TR] = u_hi;  tv[CORNER_TR] = v_lo;
    tu[CORNER_BR] = u_hi;  tv[CORNER_BR] = v_hi;
    tu[CORNER_BL] = u_lo;  tv[CORNER_BL] = v_hi;
    for (int k = 0; k < 4; k++) begin
      cw = '0;
      cw.cmd_idx = cmd_count;
      cw.spr_num = sprite_count;
      cw.corner = 2'(k);
      cw.pos_x = 18'(px[k] + ox);
      cw.pos_y = 18'(py[k] + oy);
      cw.tex_u = tu[k];
      cw.tex_v = tv[k];
      cw.pix_mode = pmod[5:3];
      cw.pixel_transparency = !pmod[6];
      cw.gouraud = pmod[2];
      cw.texture_address = {srca, 3'b000};
      cw.palette_value = (pmod[5:3] == PAL_MODE_LUT) ? {colr, 3'b000} : {3'b000, colr};
      expected_corners.insert(expected_corners.size(), cw);
    end
    sprite_count = sprite_count + 1'b1;
  endfunction

  function automatic void take_command_word(logic [15:0] w, logic list_start);
    if (list_start) begin
      org_x = '0;
      org_y = '0;
      cmd_count = '0;
      sprite_count = '0;
      fill_pos = 0;
    end
    if (fill_pos < ENTRY_WORDS) entry_buf[fill_pos] = w;
    if (fill_pos + 1 >= COMMAND_WORDS_DEF) begin
      decode_entry();
      cmd_count = cmd_count + 1'b1;
      fill_pos = 0;
    end else begin
      fill_pos = fill_pos + 1;
    end
  endfunction

  // called at a rising edge; returns at the edge that took the word
  task automatic send_word(logic [15:0] w, logic list_start);
    while (idle_on && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    s_tuser <= list_start;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    take_command_word(w, list_start);
    words_sent++;
    if (list_start) list_restarts++;
  endtask

  task automatic send_entry(entry_t e, logic list_start, int count = ENTRY_WORDS);
    for (int i = 0; i < count; i++) begin
      send_word(e[i], list_start && i == 0);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_corners.size() != 0) @(posedge clk);
  endtask

  function automatic entry_t make_entry(logic [15:0] ctrl, pmod, colr, srca, size,
                                        xa, ya, xb, yb, xc, yc, xd, yd);
    entry_t e;
    e[0] = ctrl;
    e[1] = 16'($urandom);
    e[2] = pmod;
    e[3] = colr;
    e[4] = srca;
    e[5] = size;
    e[6] = xa;   e[7] = ya;
    e[8] = xb;   e[9] = yb;
    e[10] = xc;  e[11] = yc;
    e[12] = xd;  e[13] = yd;
    return e;
  endfunction

  function automatic entry_t random_entry(bit drawable);
    entry_t e;
    logic [3:0] code;
    int pick;
    for (int i = 0; i < ENTRY_WORDS; i++) e[i] = 16'($urandom);
    pick = $urandom_range(9);
    if (pick < 3 || drawable) begin
      code = 4'($urandom_range(CMD_NORMAL, CMD_DISTORTED));
    end else if (pick < 5) begin
      code = CMD_LOCAL;
    end else begin
      code = 4'($urandom);
    end
    e[0][3:0] = code;
    e[0][14] = drawable ? 1'b0 : ($urandom_range(9) == 0);
    if (drawable || $urandom_range(9) != 0) begin
      e[5][13:8] = 6'($urandom_range(1, 63));
      e[5][7:0] = 8'($urandom_range(1, 255));
    end else if ($urandom_range(1)) begin
      e[5][13:8] = '0;
    end else begin
      e[5][7:0] = '0;
    end
    return e;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // sampled at the falling edge, where both sides of the handshake are settled
  always @(negedge clk) begin
    corner_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_corners.size() == 0) begin
        $display("%0t: unexpected corner word, expected none actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = expected_corners.pop_front();
        check_field("cmd_idx", want.cmd_idx, got.cmd_idx);
        check_field("spr_num", want.spr_num, got.spr_num);
        check_field("corner", want.corner, got.corner);
        check_field("pos_x", want.pos_x, got.pos_x);
        check_field("pos_y", want.pos_y, got.pos_y);
        check_field("tex_u", want.tex_u, got.tex_u);
        check_field("tex_v", want.tex_v, got.tex_v);
        check_field("pix_mode", want.pix_mode, got.pix_mode);
        check_field("pixel_transparency", want.pixel_transparency, got.pixel_transparency);
        check_field("gouraud", want.gouraud, got.gouraud);
        check_field("texture_address", want.texture_address, got.texture_address);
        check_field("palette_value", want.palette_value, got.palette_value);
        check_field("padding", want.pad, got.pad);
        corners_checked++;
      end
    end
  end

  // receiver: random idling, or a long hold when asked
  always @(posedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 10);
    end
  end

  task automatic test_sprite_kinds();
    // origin at the positive limit with the largest normal sprite
    send_entry(make_entry({12'h000, CMD_LOCAL}, '0, '0, '0, '0, 16'h7FFF, 16'h7FFF,
                          '0, '0, '0, '0, '0, '0), 1'b1);
    send_entry(make_entry({12'h000, CMD_NORMAL}, 16'h0008, 16'hFFFF, 16'hFFFF, 16'h3FFF,
                          16'h7FFF, 16'h7FFF, '0, '0, '0, '0, '0, '0), 1'b0);
    send_entry(make_entry({12'h000, CMD_LOCAL}, '0, '0, '0, '0, 16'h8000, 16'h8000,
                          '0, '0, '0, '0, '0, '0), 1'b0);
    // both flips, every mode bit set
    send_entry(make_entry({12'h003, CMD_SCALED}, 16'hFFFF, 16'h1234, 16'h0000, 16'hFFFF,
                          16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h7FFF,
                          '0, '0), 1'b0);
    send_entry(make_entry({12'h001, CMD_DISTORTED}, 16'h0000, 16'h0000, 16'h0000, 16'h0101,
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)), 1'b0);
    send_entry(make_entry({12'h000, CMD_LOCAL}, '0, '0, '0, '0, '0, '0,
                          '0, '0, '0, '0, '0, '0), 1'b0);
    send_entry(make_entry({12'h002, CMD_NORMAL}, 16'h0044, 16'h00FF, 16'h8000, 16'hC101,
                          '0, '0, '0, '0, '0, '0, '0, '0), 1'b0);
  endtask

  task automatic test_no_draw_commands();
    entry_t e;
    // no idling on either side through this stretch
    idle_on = 1'b0;
    // a spread of the non-sprite codes
    for (int c = CMD_DISTORTED + 1; c < 16; c += 3) begin
      if (c != CMD_LOCAL) begin
        e = random_entry(1'b1);
        e[0][3:0] = 4'(c);
        send_entry(e, 1'b0);
      end
    end
    for (int j = 4; j < 8; j++) begin
      e = random_entry(1'b1);
      e[0][14:12] = 3'(j);
      send_entry(e, 1'b0);
    end
    // zero width, then zero height
    e = random_entry(1'b1);
    e[5] = 16'hC0FF;
    send_entry(e, 1'b0);
    e = random_entry(1'b1);
    e[5] = 16'h3F00;
    send_entry(e, 1'b0);
    send_entry(random_entry(1'b1), 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_list_restart();
    send_entry(make_entry({12'h000, CMD_LOCAL}, '0, '0, '0, '0, 16'h0100, 16'hFF00,
                          '0, '0, '0, '0, '0, '0), 1'b0);
    send_entry(random_entry(1'b1), 1'b0, 5);
    // restart mid-entry drops the partial words and clears the origin
    send_entry(random_entry(1'b1), 1'b1);
    send_entry(random_entry(1'b1), 1'b0, ENTRY_WORDS - 1);
    send_entry(random_entry(1'b1), 1'b1);
  endtask

  task automatic test_backpressure();
    hold_asked++;
    for (int i = 0; i < 5; i++) send_entry(random_entry(1'b1), 1'b0);
    wait_drained();
  endtask

  task automatic test_random_lists();
    int start_words;
    bit restart_due;
    start_words = words_sent;
    restart_due = 1'b1;
    while (words_sent - start_words < RANDOM_WORDS) begin
      if ($urandom_range(99) < 10) begin
        send_entry(random_entry(1'b0), 1'b1, $urandom_range(1, ENTRY_WORDS - 1));
        restart_due = 1'b1;
      end else begin
        send_entry(random_entry(1'b0), restart_due || $urandom_range(19) == 0);
        restart_due = 1'b0;
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sprite_kinds();
    test_no_draw_commands();
    test_list_restart();
    test_backpressure();
    test_random_lists();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d command words in %0d lists, %0d corner words checked",
             words_sent, list_restarts, corners_checked);
    $display("sprite kinds, skipped and empty entries, restarts and output stalls");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
design/scg_pkg.sv
design/scg_front.sv
design/scg_queue.sv
design/scg_back.sv
design/sprite_command_geometry.sv
bench/tb.sv
